@@ hdl/cbrf_pkg.sv @@
// Shared widths, constants, types and helpers of the cubic bisection root finder.
package cbrf_pkg;

	localparam int VALUE_WIDTH   = 24;
	localparam int FRACTION_BITS = 16;
	localparam int TOL_W         = 16;
	localparam int CNT_W         = 6;
	localparam int MAX_STEPS     = 63;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(6);

	// Digit width of the shared multiplier: one digit of the multiplicand times the magnitude.
	localparam int MUL_DIGIT = 24;
	localparam int ND1       = (VALUE_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int ND2       = (2 * VALUE_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int MC_W      = ND2 * MUL_DIGIT;
	localparam int ACC_W     = MC_W + VALUE_WIDTH;
	localparam int IDX_W     = (ND2 > 1) ? $clog2(ND2) : 1;
	localparam int PROD_W    = MUL_DIGIT + VALUE_WIDTH;

	localparam int LIN_W   = VALUE_WIDTH + 2 * FRACTION_BITS + 2;
	localparam int KON_W   = 3 * FRACTION_BITS + 4;
	localparam int MAX_LK  = (LIN_W > KON_W) ? LIN_W : KON_W;
	localparam int POLY_W  = ((ACC_W > MAX_LK) ? ACC_W : MAX_LK) + 2;
	localparam logic [POLY_W-1:0] KON = POLY_W'(9) << (3 * FRACTION_BITS);

	localparam int CMP_W = (VALUE_WIDTH + 1 > TOL_W) ? VALUE_WIDTH + 1 : TOL_W;

	typedef struct packed {
		logic neg;
		logic nz;
	} sign_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		sign_t sgn;
	} poly_stat_t;

	typedef enum logic [2:0] {
		P_IDLE,
		P_PREP,
		P_MUL,
		P_CMP
	} poly_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_LAUNCH_LO,
		T_WAIT_LO,
		T_LAUNCH_HI,
		T_WAIT_HI,
		T_LAUNCH_MID,
		T_WAIT_MID,
		T_FINISH
	} top_state_t;

	// True when both values are nonzero and of opposite sign.
	function automatic logic opposite(sign_t p, sign_t q);
		return p.nz && q.nz && (p.neg != q.neg);
	endfunction

endpackage

@@ hdl/cbrf_req_if.sv @@
// Input channel carrying one search interval.
interface cbrf_req_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [cbrf_pkg::VALUE_WIDTH-1:0]    lower_end;
	logic signed [cbrf_pkg::VALUE_WIDTH-1:0]    upper_end;

	modport source(output valid, output lower_end, output upper_end, input ready);
	modport sink(input valid, input lower_end, input upper_end, output ready);
endinterface

@@ hdl/cbrf_rsp_if.sv @@
// Output channel carrying one root result.
interface cbrf_rsp_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [cbrf_pkg::VALUE_WIDTH-1:0]    root_value;
	logic [cbrf_pkg::CNT_W-1:0]                 iteration_count;
	logic                                       interval_valid;

	modport source(output valid, output root_value, output iteration_count,
		output interval_valid, input ready);
	modport sink(input valid, input root_value, input iteration_count,
		input interval_valid, output ready);
endinterface

@@ hdl/cbrf_cfg_if.sv @@
// Configuration write channel for the stop tolerance register.
interface cbrf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cbrf_pkg::TOL_W-1:0]     stop_tolerance;

	modport source(output valid, output stop_tolerance, input ready);
	modport sink(input valid, input stop_tolerance, output ready);
endinterface

@@ hdl/cbrf_poly_sign.sv @@
// Multi-cycle evaluator of the sign of the scaled cubic at one fixed-point point.
module cbrf_poly_sign (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [cbrf_pkg::VALUE_WIDTH-1:0] x,
	output cbrf_pkg::poly_stat_t                    stat
);

	cbrf_pkg::poly_state_t state_q, state_d;

	logic [cbrf_pkg::VALUE_WIDTH-1:0] x_u;
	logic [cbrf_pkg::VALUE_WIDTH-1:0] mag_c;
	logic [cbrf_pkg::VALUE_WIDTH-1:0] mag_q;
	logic                             neg_q;
	logic [cbrf_pkg::POLY_W-1:0]      lin;
	logic [cbrf_pkg::POLY_W-1:0]      c_q;
	logic [cbrf_pkg::MC_W-1:0]        mc_q;
	logic [cbrf_pkg::ACC_W-1:0]       acc_q;
	logic [cbrf_pkg::ACC_W-1:0]       acc_next;
	logic [cbrf_pkg::PROD_W-1:0]      prod;
	logic [cbrf_pkg::IDX_W-1:0]       idx_q;
	logic                             pass_q;
	logic                             last;
	logic [cbrf_pkg::POLY_W-1:0]      cube;
	logic [cbrf_pkg::POLY_W-1:0]      r;

	assign x_u   = x;
	assign mag_c = x[cbrf_pkg::VALUE_WIDTH-1] ? (~x_u + 1'b1) : x_u;
	assign lin   = cbrf_pkg::POLY_W'(mag_q) << (2 * cbrf_pkg::FRACTION_BITS + 2);

	// One digit of the multiplicand per cycle, placed at its weight in the accumulator.
	assign prod     = mc_q[cbrf_pkg::MUL_DIGIT-1:0] * mag_q;
	assign acc_next = acc_q
		+ (cbrf_pkg::ACC_W'(prod) << (int'(idx_q) * cbrf_pkg::MUL_DIGIT));
	assign last     = pass_q ? (idx_q == cbrf_pkg::IDX_W'(cbrf_pkg::ND2 - 1))
		: (idx_q == cbrf_pkg::IDX_W'(cbrf_pkg::ND1 - 1));

	// For a negative point the cube enters with opposite sign.
	assign cube = cbrf_pkg::POLY_W'(acc_q);
	assign r    = neg_q ? (c_q - cube) : (cube - c_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbrf_pkg::P_IDLE: begin
				if (start) state_d = cbrf_pkg::P_PREP;
			end
			cbrf_pkg::P_PREP: state_d = cbrf_pkg::P_MUL;
			cbrf_pkg::P_MUL: begin
				if (last && pass_q) state_d = cbrf_pkg::P_CMP;
			end
			cbrf_pkg::P_CMP: state_d = cbrf_pkg::P_IDLE;
			default: state_d = cbrf_pkg::P_IDLE;
		endcase
	end

	always_comb begin
		stat.busy    = (state_q != cbrf_pkg::P_IDLE);
		stat.done    = (state_q == cbrf_pkg::P_CMP);
		stat.sgn.neg = r[cbrf_pkg::POLY_W-1];
		stat.sgn.nz  = |r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbrf_pkg::P_IDLE;
			idx_q   <= '0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				cbrf_pkg::P_PREP: begin
					idx_q  <= '0;
					pass_q <= 1'b0;
				end
				cbrf_pkg::P_MUL: begin
					if (last) begin
						idx_q  <= '0;
						pass_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cbrf_pkg::P_IDLE: begin
				if (start) begin
					mag_q <= mag_c;
					neg_q <= x[cbrf_pkg::VALUE_WIDTH-1];
				end
			end
			cbrf_pkg::P_PREP: begin
				c_q   <= neg_q ? (lin - cbrf_pkg::KON) : (lin + cbrf_pkg::KON);
				mc_q  <= cbrf_pkg::MC_W'(mag_q);
				acc_q <= '0;
			end
			cbrf_pkg::P_MUL: begin
				if (last && !pass_q) begin
					// The square becomes the multiplicand of the second pass.
					mc_q  <= acc_next[cbrf_pkg::MC_W-1:0];
					acc_q <= '0;
				end else begin
					mc_q  <= mc_q >> cbrf_pkg::MUL_DIGIT;
					acc_q <= acc_next;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/cubic_bisection_root_finder.sv @@
// Bisection root finder for x^3 - 4x - 9 over signed Q8.16 intervals.
//
// An interval is taken only while the block is idle; its result appears in an output register,
// so the next interval can be taken while that result waits. Every cubic evaluation runs on
// one shared digit multiplier and runs through latch, prepare, three multiply digits and
// compare. A search takes at most 63 bisection steps. The end values of the interval are
// carried from step to step, so each step evaluates only its midpoint.
module cubic_bisection_root_finder (
	input  logic        clk,
	input  logic        arst_n,
	cbrf_req_if.sink    req,
	cbrf_rsp_if.source  rsp,
	cbrf_cfg_if.sink    cfg
);

	localparam int VW = cbrf_pkg::VALUE_WIDTH;

	cbrf_pkg::top_state_t state_q, state_d;
	cbrf_pkg::poly_stat_t pstat;

	logic signed [VW-1:0]           a_q, b_q, mid_q, prev_q;
	logic signed [VW-1:0]           mid_c;
	logic signed [VW:0]             sum;
	logic signed [VW:0]             dif;
	logic [VW:0]                    dif_abs;
	logic                           converged;
	cbrf_pkg::sign_t                sa_q, sb_q;
	logic [cbrf_pkg::CNT_W-1:0]     steps_q;
	logic                           ok_q;
	logic [cbrf_pkg::TOL_W-1:0]     tol_q;
	logic                           poly_start;
	logic signed [VW-1:0]           poly_x;
	logic                           out_free;
	logic                           at_limit;
	logic                           in_ready;

	logic                           out_valid_q;
	logic signed [VW-1:0]           root_q;
	logic [cbrf_pkg::CNT_W-1:0]     cnt_q;
	logic                           okout_q;

	// Midpoint rounds toward minus infinity.
	assign sum   = {a_q[VW-1], a_q} + {b_q[VW-1], b_q};
	assign mid_c = sum[VW:1];

	assign dif       = {mid_q[VW-1], mid_q} - {prev_q[VW-1], prev_q};
	assign dif_abs   = dif[VW] ? (~dif + 1'b1) : dif;
	assign converged = (cbrf_pkg::CMP_W'(dif_abs) <= cbrf_pkg::CMP_W'(tol_q));
	assign at_limit  = (steps_q == cbrf_pkg::CNT_W'(cbrf_pkg::MAX_STEPS));
	assign out_free  = !out_valid_q || rsp.ready;

	cbrf_poly_sign u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (poly_start),
		.x      (poly_x),
		.stat   (pstat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbrf_pkg::T_IDLE: begin
				if (req.valid) state_d = cbrf_pkg::T_LAUNCH_LO;
			end
			cbrf_pkg::T_LAUNCH_LO: state_d = cbrf_pkg::T_WAIT_LO;
			cbrf_pkg::T_WAIT_LO: begin
				if (pstat.done) state_d = cbrf_pkg::T_LAUNCH_HI;
			end
			cbrf_pkg::T_LAUNCH_HI: state_d = cbrf_pkg::T_WAIT_HI;
			cbrf_pkg::T_WAIT_HI: begin
				if (pstat.done) begin
					if (cbrf_pkg::opposite(sa_q, pstat.sgn)) state_d = cbrf_pkg::T_LAUNCH_MID;
					else state_d = cbrf_pkg::T_FINISH;
				end
			end
			cbrf_pkg::T_LAUNCH_MID: state_d = cbrf_pkg::T_WAIT_MID;
			cbrf_pkg::T_WAIT_MID: begin
				if (pstat.done) begin
					if (converged || at_limit) state_d = cbrf_pkg::T_FINISH;
					else state_d = cbrf_pkg::T_LAUNCH_MID;
				end
			end
			cbrf_pkg::T_FINISH: begin
				if (out_free) state_d = cbrf_pkg::T_IDLE;
			end
			default: state_d = cbrf_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == cbrf_pkg::T_IDLE);
		poly_start = state_q inside {cbrf_pkg::T_LAUNCH_LO, cbrf_pkg::T_LAUNCH_HI,
			cbrf_pkg::T_LAUNCH_MID};
		case (state_q)
			cbrf_pkg::T_LAUNCH_LO: poly_x = a_q;
			cbrf_pkg::T_LAUNCH_HI: poly_x = b_q;
			default:               poly_x = mid_c;
		endcase
	end

	assign req.ready           = in_ready;
	assign cfg.ready           = 1'b1;
	assign rsp.valid           = out_valid_q;
	assign rsp.root_value      = root_q;
	assign rsp.iteration_count = cnt_q;
	assign rsp.interval_valid  = okout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbrf_pkg::T_IDLE;
			tol_q       <= cbrf_pkg::TOL_RESET;
			out_valid_q <= 1'b0;
			steps_q     <= '0;
			ok_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) tol_q <= cfg.stop_tolerance;
			if (state_q == cbrf_pkg::T_FINISH && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				cbrf_pkg::T_IDLE: begin
					if (req.valid) steps_q <= '0;
				end
				cbrf_pkg::T_WAIT_HI: begin
					if (pstat.done) ok_q <= cbrf_pkg::opposite(sa_q, pstat.sgn);
				end
				cbrf_pkg::T_LAUNCH_MID: steps_q <= steps_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cbrf_pkg::T_IDLE: begin
				if (req.valid) begin
					a_q    <= req.lower_end;
					b_q    <= req.upper_end;
					prev_q <= req.upper_end;
				end
			end
			cbrf_pkg::T_WAIT_LO: begin
				if (pstat.done) sa_q <= pstat.sgn;
			end
			cbrf_pkg::T_WAIT_HI: begin
				if (pstat.done) sb_q <= pstat.sgn;
			end
			cbrf_pkg::T_LAUNCH_MID: mid_q <= mid_c;
			cbrf_pkg::T_WAIT_MID: begin
				if (pstat.done) begin
					// A zero at the midpoint keeps both ends where they are.
					if (cbrf_pkg::opposite(sa_q, pstat.sgn)) begin
						b_q  <= mid_q;
						sb_q <= pstat.sgn;
					end else if (cbrf_pkg::opposite(pstat.sgn, sb_q)) begin
						a_q  <= mid_q;
						sa_q <= pstat.sgn;
					end
					prev_q <= mid_q;
				end
			end
			cbrf_pkg::T_FINISH: begin
				if (out_free) begin
					root_q  <= ok_q ? mid_q : '0;
					cnt_q   <= ok_q ? steps_q : '0;
					okout_q <= ok_q;
				end
			end
			default: ;
		endcase
	end

	a_idle_poly: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pstat.busy)
		else $error("input ready while the cubic evaluator is busy");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.interval_valid) |-> (rsp.root_value == '0 && rsp.iteration_count == '0))
		else $error("invalid interval result is not all zero");

	a_valid_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.interval_valid) |-> (rsp.iteration_count != '0))
		else $error("valid interval result reports no steps");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		pstat.done |-> (state_q == cbrf_pkg::T_WAIT_LO || state_q == cbrf_pkg::T_WAIT_HI
			|| state_q == cbrf_pkg::T_WAIT_MID))
		else $error("cubic evaluation finished with nobody waiting for it");

endmodule

@@ tb/sv/tb_cubic_bisection_root_finder.sv @@
// Self-checking testbench for the cubic bisection root finder with randomized flow control.
module tb_cubic_bisection_root_finder;
	import cbrf_pkg::*;

	localparam int  VALUE_MIN   = -(1 << (VALUE_WIDTH - 1));
	localparam int  VALUE_MAX   = (1 << (VALUE_WIDTH - 1)) - 1;
	localparam int  ROOT_RAW    = 177375;
	localparam int  RANDOM_ITEMS = 1600;
	localparam int  PHASES      = 6;
	localparam int  CYCLE_LIMIT = 4000000;
	localparam int  DRAIN_CYCLES = 400;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_RUNS
	} stall_mode_t;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] lower;
		logic signed [VALUE_WIDTH-1:0] upper;
	} span_t;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] root;
		logic [CNT_W-1:0]              count;
		logic                          valid;
	} root_rec_t;

	logic clk;
	logic arst_n;

	cbrf_req_if req_ch();
	cbrf_rsp_if rsp_ch();
	cbrf_cfg_if cfg_ch();

	cubic_bisection_root_finder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	span_t       spans_to_send[$];
	root_rec_t   roots_due[$];
	logic [TOL_W-1:0] tol_now = TOL_RESET;
	int          n_queued = 0;
	int          n_accepted = 0;
	int          n_faults = 0;
	int          cycle_cnt = 0;
	bit          steady = 0;
	bit          req_took = 0;

	// Sign of x^3 - 4x - 9 at a raw Q8.16 value, evaluated exactly on the scaled polynomial.
	function automatic int cubic_sign(longint x);
		logic signed [127:0] xx;
		logic signed [127:0] f;
		xx = x;
		f = xx * xx * xx - (xx <<< (2 * FRACTION_BITS + 2)) - (128'sd9 <<< (3 * FRACTION_BITS));
		if (f[127])
			return -1;
		return (f != 0) ? 1 : 0;
	endfunction

	function automatic root_rec_t solve_root(span_t s, logic [TOL_W-1:0] tol);
		longint    a;
		longint    b;
		longint    mid;
		longint    prev;
		longint    diff;
		int        steps;
		int        sl;
		int        sm;
		int        sr;
		bit        done;
		root_rec_t r;
		a = s.lower;
		b = s.upper;
		prev = b;
		mid = 0;
		steps = 0;
		done = 0;
		r.root = '0;
		r.count = '0;
		r.valid = 1'b0;
		if (cubic_sign(a) * cubic_sign(b) >= 0)
			return r;
		while (!done) begin
			mid = (a + b) >>> 1;
			steps++;
			sl = cubic_sign(a);
			sm = cubic_sign(mid);
			sr = cubic_sign(b);
			if (sl * sm < 0)
				b = mid;
			else if (sm * sr < 0)
				a = mid;
			diff = mid - prev;
			if (diff < 0)
				diff = -diff;
			if (diff <= longint'(tol) || steps >= MAX_STEPS)
				done = 1;
			else
				prev = mid;
		end
		r.root = mid[VALUE_WIDTH-1:0];
		r.count = steps[CNT_W-1:0];
		r.valid = 1'b1;
		return r;
	endfunction

	// Mostly intervals that bracket the root at many widths, plus full-range noise.
	function automatic span_t random_span();
		span_t s;
		int    pick;
		int    lo;
		int    hi;
		int    mask;
		int    tmp;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			s.lower = VALUE_WIDTH'($urandom);
			s.upper = VALUE_WIDTH'($urandom);
			return s;
		end
		if (pick < 22) begin
			lo = ROOT_RAW - $urandom_range(0, 2000);
			hi = ROOT_RAW + $urandom_range(0, 2000);
		end else begin
			mask = (1 << $urandom_range(0, VALUE_WIDTH - 1)) - 1;
			lo = 177000 - int'($urandom & mask);
			hi = 178000 + int'($urandom & mask);
			if (hi > VALUE_MAX)
				hi = VALUE_MAX;
		end
		if ($urandom_range(0, 1)) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		s.lower = lo[VALUE_WIDTH-1:0];
		s.upper = hi[VALUE_WIDTH-1:0];
		return s;
	endfunction

	task automatic queue_span(int lo, int hi);
		span_t s;
		s.lower = lo[VALUE_WIDTH-1:0];
		s.upper = hi[VALUE_WIDTH-1:0];
		spans_to_send.push_back(s);
		n_queued++;
	endtask

	task automatic report_fault(string msg);
		n_faults++;
		if (n_faults <= 10)
			$display("ERROR at cycle %0d: %s", cycle_cnt, msg);
	endtask

	// Called at a falling edge; returns at a falling edge with every result back.
	task automatic wait_drained();
		while (n_accepted != n_queued || roots_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_tolerance(logic [TOL_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.stop_tolerance <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		tol_now = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Input side: each transfer is predicted from the tolerance in force.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			span_t s;
			s.lower = req_ch.lower_end;
			s.upper = req_ch.upper_end;
			roots_due.push_back(solve_root(s, tol_now));
			n_accepted++;
			req_took = 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			root_rec_t want;
			if (roots_due.size() == 0) begin
				report_fault($sformatf("result root=%0d count=%0d valid=%0b with none expected",
					rsp_ch.root_value, rsp_ch.iteration_count, rsp_ch.interval_valid));
			end else begin
				want = roots_due.pop_front();
				if (rsp_ch.root_value !== want.root || rsp_ch.iteration_count !== want.count ||
						rsp_ch.interval_valid !== want.valid)
					report_fault($sformatf(
						"expected root=%0d count=%0d valid=%0b, got root=%0d count=%0d valid=%0b",
						want.root, want.count, want.valid, rsp_ch.root_value,
						rsp_ch.iteration_count, rsp_ch.interval_valid));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sender: bursts of transfers separated by random gaps.
	int gap_left = 0;
	int burst_left = 1;

	always @(negedge clk) begin
		span_t nx;
		if (arst_n && (!req_ch.valid || req_took)) begin
			req_took = 0;
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (spans_to_send.size() > 0) begin
				nx = spans_to_send.pop_front();
				req_ch.lower_end <= nx.lower;
				req_ch.upper_end <= nx.upper;
				req_ch.valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					if (steady || $urandom_range(0, 3) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 12);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: switches between no stalls, random stalls and long stall runs.
	stall_mode_t stall_mode = STALL_NONE;
	int  mode_left = 0;
	int  run_left = 0;
	bit  run_ready = 1;

	always @(negedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 400);
				case ($urandom_range(0, 2))
					0: stall_mode = STALL_NONE;
					1: stall_mode = STALL_RANDOM;
					default: stall_mode = STALL_RUNS;
				endcase
				if (steady)
					stall_mode = STALL_NONE;
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE: rsp_ch.ready <= 1'b1;
				STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (run_left == 0) begin
						run_ready = !run_ready;
						run_left = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 30);
					end
					run_left--;
					rsp_ch.ready <= run_ready;
				end
			endcase
		end
	end

	initial begin
		int per_phase;
		req_ch.valid = 1'b0;
		req_ch.lower_end = '0;
		req_ch.upper_end = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.stop_tolerance = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed intervals under the reset tolerance.
		queue_span(VALUE_MIN, VALUE_MAX);
		queue_span(VALUE_MAX, VALUE_MIN);
		queue_span(0, VALUE_MAX);
		queue_span(-1, VALUE_MAX);
		queue_span(VALUE_MIN, -1);
		queue_span(VALUE_MAX, 200000);
		queue_span(VALUE_MIN, VALUE_MIN);
		queue_span(VALUE_MAX, VALUE_MAX);
		queue_span(0, 0);
		queue_span(ROOT_RAW, ROOT_RAW);
		queue_span(ROOT_RAW - 1, ROOT_RAW + 1);
		queue_span(ROOT_RAW + 1, ROOT_RAW - 1);
		queue_span(ROOT_RAW, ROOT_RAW + 1);
		queue_span(ROOT_RAW - 1, ROOT_RAW);
		queue_span(177000, 178000);
		queue_span(196608, 131072);
		queue_span(131072, 196608);
		wait_drained();

		per_phase = RANDOM_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1: write_tolerance('0);
				2: write_tolerance('1);
				3: write_tolerance(TOL_W'(1));
				4: write_tolerance(TOL_W'($urandom_range(2, 65534)));
				5: write_tolerance(TOL_RESET);
				default: ;
			endcase
			steady = (ph == 3) || ($urandom_range(0, 3) == 0);
			for (int i = 0; i < per_phase; i++)
				spans_to_send.push_back(random_span());
			n_queued += per_phase;
			// The next phase is held off here until every result of this phase is back.
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (roots_due.size() != 0)
			report_fault($sformatf("%0d results never arrived", roots_due.size()));
		if (n_faults == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/cbrf_pkg.sv
hdl/cbrf_req_if.sv
hdl/cbrf_rsp_if.sv
hdl/cbrf_cfg_if.sv
hdl/cbrf_poly_sign.sv
hdl/cubic_bisection_root_finder.sv
tb/sv/tb_cubic_bisection_root_finder.sv
